// ===== rtl/core/wpd_pkg.sv =====
// Package: shared types and constants of the WAV PCM stream decoder.
package wpd_pkg;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_CHDR = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_DATA = 3'd4,
        PH_DONE = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_SAMPLE    = 2'd0,
        KIND_HEADER    = 2'd1,
        KIND_REJECT    = 2'd2,
        KIND_EARLY_END = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        CAUSE_BAD_TAG  = 3'd0,
        CAUSE_NOT_PCM  = 3'd1,
        CAUSE_BAD_CH   = 3'd2,
        CAUSE_BAD_BITS = 3'd3,
        CAUSE_NO_FMT   = 3'd4
    } t_cause;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;
    localparam logic [7:0]  PCM_BIAS = 8'h80;

    // One classified result on its way from the parser to the output stage.
    typedef struct packed {
        t_kind       kind;
        logic        is8;       // value[7:0] holds a raw unsigned 8-bit sample
        logic [15:0] value;
        logic [1:0]  channels;
        logic [31:0] rate;
        logic [4:0]  bits;
        logic [31:0] total;
        t_cause      cause;
        logic        last;
    } t_evt;

endpackage

// ===== rtl/core/wav_pcm_stream_decoder.sv =====
// Top level: WAV PCM stream decoder, parser front end, result queue and output stage.
//
//  channel | side   | handshake              | fields
//  --------+--------+------------------------+---------------------------------------------
//  byte in | input  | i_push / o_full        | i_op, i_data_byte
//  result  | output | o_empty / i_pop        | o_kind, o_sample, o_channels, o_sample_rate,
//          |        |                        | o_bits_per_sample, o_total_samples,
//          |        |                        | o_reject_cause, o_last
//
// One byte is taken every cycle while o_full is low, and each one updates the parser state.
// Each result passes through the result queue and the output register to the output ports.
// o_full rises once QUEUE_DEPTH results sit in the queue with one more held in the
// output register behind a stalled consumer; while it is high every byte waits.
// Reset is synchronous and active low; it empties the queue and the output register
// and puts the parser at the start of a RIFF header. No clearing pass is needed.
module wav_pcm_stream_decoder
    import wpd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic               i_op,
    input  logic [7:0]         i_data_byte,
    output logic               o_empty,
    input  logic               i_pop,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_sample,
    output logic [1:0]         o_channels,
    output logic [31:0]        o_sample_rate,
    output logic [4:0]         o_bits_per_sample,
    output logic [31:0]        o_total_samples,
    output logic [2:0]         o_reject_cause,
    output logic               o_last
);

    logic byte_accept;
    logic evt_valid;
    t_evt evt;
    logic q_empty;
    logic q_pop;
    t_evt q_evt;

    // A transaction is taken whenever the queue has room, result or not.
    assign byte_accept = i_push && !o_full;

    wpd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (byte_accept),
        .i_op        (i_op),
        .i_data_byte (i_data_byte),
        .o_evt_valid (evt_valid),
        .o_evt       (evt)
    );

    wpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (evt_valid),
        .i_evt   (evt),
        .o_full  (o_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_evt   (q_evt)
    );

    wpd_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_empty         (q_empty),
        .i_q_evt           (q_evt),
        .o_q_pop           (q_pop),
        .i_pop             (i_pop),
        .o_empty           (o_empty),
        .o_kind            (o_kind),
        .o_sample          (o_sample),
        .o_channels        (o_channels),
        .o_sample_rate     (o_sample_rate),
        .o_bits_per_sample (o_bits_per_sample),
        .o_total_samples   (o_total_samples),
        .o_reject_cause    (o_reject_cause),
        .o_last            (o_last)
    );

endmodule

// ===== rtl/core/wpd_front.sv =====
// Front end: byte-level RIFF/WAVE parser that classifies each byte into zero or one result.
module wpd_front
    import wpd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_op,
    input  logic [7:0] i_data_byte,
    output logic       o_evt_valid,
    output t_evt       o_evt
);

    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_rem, n_rem;
    logic [31:0] r_fa, n_fa;
    logic [1:0]  r_ch, n_ch;
    logic [4:0]  r_bits, n_bits;
    logic [31:0] r_freq, n_freq;
    logic        r_fmt_seen, n_fmt_seen;
    logic [31:0] r_left, n_left;
    logic [7:0]  r_hold, n_hold;

    logic [3:0]  p;
    logic [31:0] byte_w;
    logic [31:0] fa_new;
    logic [1:0]  frame_shift;
    logic [31:0] frames;
    logic [31:0] samples;
    logic [31:0] rem_dec;

    assign p       = r_pos;
    assign byte_w  = {24'd0, i_data_byte};
    assign rem_dec = r_rem - 32'd1;

    // Sample count for a data chunk: frames from the byte length, times channels.
    assign frame_shift = {1'b0, r_ch == 2'd2} + {1'b0, r_bits == 5'd16};
    assign frames      = fa_new >> frame_shift;
    assign samples     = (r_ch == 2'd2) ? {frames[30:0], 1'b0} : frames;

    // Field assembly, little endian, for chunk header and fmt body.
    always_comb begin
        fa_new = r_fa;
        if (r_phase == PH_CHDR) begin
            if (p >= 4'd4 && p <= 4'd7) begin
                fa_new = r_fa | (byte_w << {p[1:0], 3'b000});
            end
        end else if (r_phase == PH_FMT) begin
            if (p >= 4'd4 && p <= 4'd7) begin
                fa_new = r_fa | (byte_w << {p[1:0], 3'b000});
            end else if (p < 4'd4 || p >= 4'd14) begin
                fa_new = r_fa | (byte_w << {p[0], 3'b000});
            end
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_tag       = r_tag;
        n_rem       = r_rem;
        n_fa        = r_fa;
        n_ch        = r_ch;
        n_bits      = r_bits;
        n_freq      = r_freq;
        n_fmt_seen  = r_fmt_seen;
        n_left      = r_left;
        n_hold      = r_hold;
        o_evt_valid = 1'b0;
        o_evt       = '0;

        if (i_accept) begin
            if (i_op) begin
                if (r_phase != PH_DONE) begin
                    o_evt_valid = 1'b1;
                    o_evt.kind  = KIND_EARLY_END;
                end
                n_phase    = PH_RIFF;
                n_pos      = '0;
                n_tag      = '0;
                n_rem      = '0;
                n_fa       = '0;
                n_ch       = '0;
                n_bits     = '0;
                n_freq     = '0;
                n_fmt_seen = 1'b0;
                n_left     = '0;
                n_hold     = '0;
            end else begin
                unique case (r_phase)
                    PH_RIFF: begin
                        n_tag = {r_tag[23:0], i_data_byte};
                        n_pos = p + 4'd1;
                        if (p == 4'd3 && n_tag != TAG_RIFF) begin
                            n_phase     = PH_DONE;
                            o_evt_valid = 1'b1;
                            o_evt.kind  = KIND_REJECT;
                            o_evt.cause = CAUSE_BAD_TAG;
                        end else if (p == 4'd11) begin
                            if (n_tag != TAG_WAVE) begin
                                n_phase     = PH_DONE;
                                o_evt_valid = 1'b1;
                                o_evt.kind  = KIND_REJECT;
                                o_evt.cause = CAUSE_BAD_TAG;
                            end else begin
                                n_phase = PH_CHDR;
                                n_pos   = '0;
                                n_fa    = '0;
                            end
                        end
                    end
                    PH_CHDR: begin
                        if (p < 4'd4) begin
                            n_tag = {r_tag[23:0], i_data_byte};
                        end
                        n_fa  = fa_new;
                        n_pos = p + 4'd1;
                        if (p == 4'd7) begin
                            n_fa  = '0;
                            n_pos = '0;
                            if (r_tag == TAG_FMT) begin
                                n_rem   = fa_new;
                                n_phase = PH_FMT;
                            end else if (r_tag == TAG_DATA) begin
                                o_evt_valid = 1'b1;
                                if (!r_fmt_seen) begin
                                    n_phase     = PH_DONE;
                                    o_evt.kind  = KIND_REJECT;
                                    o_evt.cause = CAUSE_NO_FMT;
                                end else begin
                                    n_left         = samples;
                                    o_evt.kind     = KIND_HEADER;
                                    o_evt.channels = r_ch;
                                    o_evt.rate     = r_freq;
                                    o_evt.bits     = r_bits;
                                    o_evt.total    = samples;
                                    n_phase = (samples == 32'd0) ? PH_DONE : PH_DATA;
                                end
                            end else begin
                                n_rem   = fa_new;
                                n_phase = (fa_new == 32'd0) ? PH_CHDR : PH_SKIP;
                            end
                        end
                    end
                    PH_FMT: begin
                        n_fa  = fa_new;
                        n_pos = p + 4'd1;
                        unique case (p)
                            4'd1: begin
                                if (fa_new != 32'd1) begin
                                    n_phase     = PH_DONE;
                                    o_evt_valid = 1'b1;
                                    o_evt.kind  = KIND_REJECT;
                                    o_evt.cause = CAUSE_NOT_PCM;
                                end else begin
                                    n_fa = '0;
                                end
                            end
                            4'd3: begin
                                if (fa_new != 32'd1 && fa_new != 32'd2) begin
                                    n_phase     = PH_DONE;
                                    o_evt_valid = 1'b1;
                                    o_evt.kind  = KIND_REJECT;
                                    o_evt.cause = CAUSE_BAD_CH;
                                end else begin
                                    n_ch = fa_new[1:0];
                                    n_fa = '0;
                                end
                            end
                            4'd7: begin
                                n_freq = fa_new;
                                n_fa   = '0;
                            end
                            4'd15: begin
                                if (fa_new != 32'd8 && fa_new != 32'd16) begin
                                    n_phase     = PH_DONE;
                                    o_evt_valid = 1'b1;
                                    o_evt.kind  = KIND_REJECT;
                                    o_evt.cause = CAUSE_BAD_BITS;
                                end else begin
                                    // Skip whatever the chunk holds past the 16 fmt bytes.
                                    n_bits     = fa_new[4:0];
                                    n_fa       = '0;
                                    n_fmt_seen = 1'b1;
                                    n_pos      = '0;
                                    if (r_rem > 32'd16) begin
                                        n_rem   = r_rem - 32'd16;
                                        n_phase = PH_SKIP;
                                    end else begin
                                        n_rem   = '0;
                                        n_phase = PH_CHDR;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                    PH_SKIP: begin
                        n_rem = rem_dec;
                        if (rem_dec == 32'd0) begin
                            n_phase = PH_CHDR;
                            n_pos   = '0;
                            n_fa    = '0;
                        end
                    end
                    PH_DATA: begin
                        if (r_bits != 5'd16) begin
                            o_evt_valid = 1'b1;
                            o_evt.is8   = 1'b1;
                            o_evt.value = {8'd0, i_data_byte};
                        end else if (!p[0]) begin
                            n_hold = i_data_byte;
                            n_pos  = 4'd1;
                        end else begin
                            n_pos       = '0;
                            o_evt_valid = 1'b1;
                            o_evt.value = {i_data_byte, r_hold};
                        end
                        if (o_evt_valid) begin
                            o_evt.kind = KIND_SAMPLE;
                            n_left     = r_left - 32'd1;
                            if (r_left == 32'd1) begin
                                o_evt.last = 1'b1;
                                n_phase    = PH_DONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_RIFF;
            r_pos      <= '0;
            r_tag      <= '0;
            r_rem      <= '0;
            r_fa       <= '0;
            r_ch       <= '0;
            r_bits     <= '0;
            r_freq     <= '0;
            r_fmt_seen <= 1'b0;
            r_left     <= '0;
            r_hold     <= '0;
        end else begin
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_tag      <= n_tag;
            r_rem      <= n_rem;
            r_fa       <= n_fa;
            r_ch       <= n_ch;
            r_bits     <= n_bits;
            r_freq     <= n_freq;
            r_fmt_seen <= n_fmt_seen;
            r_left     <= n_left;
            r_hold     <= n_hold;
        end
    end

endmodule

// ===== rtl/core/wpd_queue.sv =====
// Result queue: short FIFO between the parser and the output stage.
module wpd_queue
    import wpd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_evt,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_evt o_evt
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_evt          r_mem [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_evt   = r_mem[r_rd];

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_evt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/core/wpd_back.sv =====
// Back end: turns queued results into output fields and holds them in the output register.
module wpd_back
    import wpd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_empty,
    input  t_evt               i_q_evt,
    output logic               o_q_pop,
    input  logic               i_pop,
    output logic               o_empty,
    output logic [1:0]         o_kind,
    output logic signed [15:0] o_sample,
    output logic [1:0]         o_channels,
    output logic [31:0]        o_sample_rate,
    output logic [4:0]         o_bits_per_sample,
    output logic [31:0]        o_total_samples,
    output logic [2:0]         o_reject_cause,
    output logic               o_last
);

    logic               r_valid, n_valid;
    logic [1:0]         r_kind;
    logic signed [15:0] r_sample;
    logic [1:0]         r_channels;
    logic [31:0]        r_rate;
    logic [4:0]         r_bits;
    logic [31:0]        r_total;
    logic [2:0]         r_cause;
    logic               r_last;
    logic [15:0]        sample_w;

    // Load a new result whenever the register is free or being taken.
    assign o_q_pop = !i_q_empty && (!r_valid || i_pop);

    // Unsigned 8-bit PCM: flip the bias bit and move to the top byte.
    assign sample_w = i_q_evt.is8 ? {i_q_evt.value[7:0] ^ PCM_BIAS, 8'h00} : i_q_evt.value;

    always_comb begin
        n_valid = r_valid;
        if (o_q_pop) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_kind     <= i_q_evt.kind;
            r_sample   <= $signed(sample_w);
            r_channels <= i_q_evt.channels;
            r_rate     <= i_q_evt.rate;
            r_bits     <= i_q_evt.bits;
            r_total    <= i_q_evt.total;
            r_cause    <= i_q_evt.cause;
            r_last     <= i_q_evt.last;
        end
    end

    assign o_empty           = !r_valid;
    assign o_kind            = r_kind;
    assign o_sample          = r_sample;
    assign o_channels        = r_channels;
    assign o_sample_rate     = r_rate;
    assign o_bits_per_sample = r_bits;
    assign o_total_samples   = r_total;
    assign o_reject_cause    = r_cause;
    assign o_last            = r_last;

endmodule

// ===== rtl/core/wpd_checker.sv =====
// Checker: port-level properties of the WAV PCM stream decoder, bound to the top level.
module wpd_checker
    import wpd_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               o_full,
    input logic               o_empty,
    input logic               i_pop,
    input logic [1:0]         o_kind,
    input logic signed [15:0] o_sample,
    input logic [1:0]         o_channels,
    input logic [31:0]        o_sample_rate,
    input logic [4:0]         o_bits_per_sample,
    input logic [31:0]        o_total_samples,
    input logic [2:0]         o_reject_cause,
    input logic               o_last
);

    // Reset leaves nothing to deliver and room for input.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (o_empty && !o_full))
        else $error("result or full flag visible right after reset");

    // Only a sample can carry the last flag.
    a_last_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_last) |-> (o_kind == KIND_SAMPLE))
        else $error("last flag on a non-sample result");

    // An accepted header always reports a legal format.
    a_header_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind == KIND_HEADER) |->
            ((o_channels == 2'd1 || o_channels == 2'd2) &&
             (o_bits_per_sample == 5'd8 || o_bits_per_sample == 5'd16) &&
             !o_last && o_reject_cause == 3'd0))
        else $error("header result with illegal format fields");

    // A sample carries no header or reject information.
    a_sample_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_kind == KIND_SAMPLE) |->
            (o_channels == 2'd0 && o_sample_rate == 32'd0 &&
             o_total_samples == 32'd0 && o_reject_cause == 3'd0))
        else $error("sample result with stray header fields");

    // A stalled result holds.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_kind) && $stable(o_sample)))
        else $error("stalled result changed");

endmodule

bind wav_pcm_stream_decoder wpd_checker u_wpd_checker (.*);

// ===== tb/sv/tb_top.sv =====
// Testbench for the WAV PCM stream decoder: byte streams in, parsed results checked.
module tb_top;
    import wpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEMS        = 1000;   // useful bytes to offer in the random part
    localparam int HOLD_CYCLES  = 300;    // long receiver stall that backs up the queue
    localparam int DRAIN_CYCLES = 16;     // extra wait once no more results are owed
    localparam int DRAIN_LIMIT  = 5000;
    localparam int MAX_SHOWN    = 10;

    // One result as it appears on the output ports.
    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] sample;
        logic [1:0]         channels;
        logic [31:0]        rate;
        logic [4:0]         bits;
        logic [31:0]        total;
        logic [2:0]         cause;
        logic               last;
    } wav_res_t;

    // One input transaction: end-of-stream flag and the byte.
    typedef struct packed {
        logic       op;
        logic [7:0] b;
    } stim_t;

    // A directed row; fixed rows carry a result typed in by hand.
    typedef struct packed {
        stim_t    s;
        bit       fixed;
        wav_res_t want;
    } dir_row_t;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               i_push      = 1'b0;
    logic               i_op        = 1'b0;
    logic [7:0]         i_data_byte = 8'h00;
    logic               i_pop       = 1'b0;
    logic               o_full;
    logic               o_empty;
    logic [1:0]         o_kind;
    logic signed [15:0] o_sample;
    logic [1:0]         o_channels;
    logic [31:0]        o_sample_rate;
    logic [4:0]         o_bits_per_sample;
    logic [31:0]        o_total_samples;
    logic [2:0]         o_reject_cause;
    logic               o_last;

    wav_pcm_stream_decoder uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (i_push),
        .o_full            (o_full),
        .i_op              (i_op),
        .i_data_byte       (i_data_byte),
        .o_empty           (o_empty),
        .i_pop             (i_pop),
        .o_kind            (o_kind),
        .o_sample          (o_sample),
        .o_channels        (o_channels),
        .o_sample_rate     (o_sample_rate),
        .o_bits_per_sample (o_bits_per_sample),
        .o_total_samples   (o_total_samples),
        .o_reject_cause    (o_reject_cause),
        .o_last            (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Results the decoder still owes, oldest first.
    wav_res_t pending_results[$];
    dir_row_t dir_rows[$];
    stim_t    stream_bytes[$];

    int  err_cnt      = 0;
    int  useful_items = 0;
    int  stream_cnt   = 0;
    int  full_cycles  = 0;
    int  tx_burst     = 0;
    int  rx_burst     = 0;
    int  kind_seen[4] = '{0, 0, 0, 0};
    bit  hold_req     = 1'b0;
    logic hold_rx     = 1'b0;

    // Parser mirror: phase, byte counter, tag shifter and the fmt fields.
    t_phase      ph;
    logic [3:0]  pos;
    logic [31:0] tag_sr;
    logic [31:0] chunk_left;
    logic [31:0] field_acc;
    logic [1:0]  chan_reg;
    logic [4:0]  bits_reg;
    logic [31:0] rate_reg;
    logic        fmt_valid;
    logic [31:0] frames_left;
    logic [7:0]  low_hold;

    function automatic void parser_restart();
        ph          = PH_RIFF;
        pos         = '0;
        tag_sr      = '0;
        chunk_left  = '0;
        field_acc   = '0;
        chan_reg    = '0;
        bits_reg    = '0;
        rate_reg    = '0;
        fmt_valid   = 1'b0;
        frames_left = '0;
        low_hold    = '0;
    endfunction

    function automatic bit take_reject(input logic [2:0] cause, output wav_res_t r);
        ph      = PH_DONE;
        r       = '0;
        r.kind  = KIND_REJECT;
        r.cause = cause;
        return 1'b1;
    endfunction

    function automatic bit take_sample(input logic [15:0] value, output wav_res_t r);
        r           = '0;
        r.kind      = KIND_SAMPLE;
        r.sample    = value;
        frames_left = frames_left - 1;
        if (frames_left == 0) begin
            r.last = 1'b1;
            ph     = PH_DONE;
        end
        return 1'b1;
    endfunction

    // Advance the parser mirror by one transaction; return 1 when it yields a result.
    function automatic bit decode_step(input logic op, input logic [7:0] b,
                                       output wav_res_t r);
        logic [3:0]  p;
        logic [31:0] len;
        logic [1:0]  shamt;
        r = '0;
        if (op) begin
            if (ph <= PH_DATA) begin
                r.kind = KIND_EARLY_END;
                parser_restart();
                return 1'b1;
            end
            parser_restart();
            return 1'b0;
        end
        p = pos;
        case (ph)
            PH_RIFF: begin
                tag_sr = {tag_sr[23:0], b};
                pos    = p + 4'd1;
                if (p == 4'd3 && tag_sr != TAG_RIFF) return take_reject(CAUSE_BAD_TAG, r);
                if (p == 4'd11) begin
                    if (tag_sr != TAG_WAVE) return take_reject(CAUSE_BAD_TAG, r);
                    ph        = PH_CHDR;
                    pos       = '0;
                    field_acc = '0;
                end
            end
            PH_CHDR: begin
                if (p < 4) tag_sr = {tag_sr[23:0], b};
                else if (p < 8) field_acc = field_acc | (32'(b) << (8 * (p - 4)));
                pos = p + 4'd1;
                if (p == 4'd7) begin
                    len       = field_acc;
                    field_acc = '0;
                    pos       = '0;
                    if (tag_sr == TAG_FMT) begin
                        chunk_left = len;
                        ph         = PH_FMT;
                    end else if (tag_sr == TAG_DATA) begin
                        if (!fmt_valid) return take_reject(CAUSE_NO_FMT, r);
                        // Frames come from bytes per frame; stereo doubles the sample count.
                        shamt       = 2'(chan_reg == 2'd2) + 2'(bits_reg == 5'd16);
                        frames_left = (len >> shamt) << ((chan_reg == 2'd2) ? 1 : 0);
                        r.kind      = KIND_HEADER;
                        r.channels  = chan_reg;
                        r.rate      = rate_reg;
                        r.bits      = bits_reg;
                        r.total     = frames_left;
                        ph          = (frames_left == 0) ? PH_DONE : PH_DATA;
                        return 1'b1;
                    end else begin
                        chunk_left = len;
                        ph         = (len == 0) ? PH_CHDR : PH_SKIP;
                    end
                end
            end
            PH_FMT: begin
                if (p >= 4 && p <= 7) field_acc = field_acc | (32'(b) << (8 * (p - 4)));
                else if (p < 4 || p >= 14) field_acc = field_acc | (32'(b) << (8 * p[0]));
                pos = p + 4'd1;
                case (p)
                    4'd1: begin
                        if (field_acc != 1) return take_reject(CAUSE_NOT_PCM, r);
                        field_acc = '0;
                    end
                    4'd3: begin
                        if (field_acc != 1 && field_acc != 2) begin
                            return take_reject(CAUSE_BAD_CH, r);
                        end
                        chan_reg  = field_acc[1:0];
                        field_acc = '0;
                    end
                    4'd7: begin
                        rate_reg  = field_acc;
                        field_acc = '0;
                    end
                    4'd15: begin
                        if (field_acc != 8 && field_acc != 16) begin
                            return take_reject(CAUSE_BAD_BITS, r);
                        end
                        bits_reg   = field_acc[4:0];
                        field_acc  = '0;
                        fmt_valid  = 1'b1;
                        chunk_left = (chunk_left > 16) ? chunk_left - 16 : 32'd0;
                        ph         = (chunk_left == 0) ? PH_CHDR : PH_SKIP;
                        pos        = '0;
                    end
                    default: ;
                endcase
            end
            PH_SKIP: begin
                chunk_left = chunk_left - 1;
                if (chunk_left == 0) begin
                    ph        = PH_CHDR;
                    pos       = '0;
                    field_acc = '0;
                end
            end
            PH_DATA: begin
                if (bits_reg != 5'd16) return take_sample({b ^ PCM_BIAS, 8'h00}, r);
                if (!pos[0]) begin
                    low_hold = b;
                    pos      = 4'd1;
                end else begin
                    pos = '0;
                    return take_sample({b, low_hold}, r);
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // Draw an idle count; now and then run a burst with no idling at all.
    function automatic int pick_gap(inout int burst);
        if (burst > 0) begin
            burst = burst - 1;
            return 0;
        end
        if ($urandom_range(0, 19) == 0) begin
            burst = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 12);
    endfunction

    function automatic void note_error(input string msg);
        err_cnt = err_cnt + 1;
        if (err_cnt <= MAX_SHOWN) $display("%s", msg);
    endfunction

    function automatic void add_row(input logic op, input logic [7:0] b);
        dir_row_t row;
        row   = '0;
        row.s = {op, b};
        dir_rows.push_back(row);
    endfunction

    function automatic void add_row_exp(input logic op, input logic [7:0] b,
                                        input t_kind k, input logic [2:0] c);
        dir_row_t row;
        row            = '0;
        row.s          = {op, b};
        row.fixed      = 1'b1;
        row.want.kind  = k;
        row.want.cause = c;
        dir_rows.push_back(row);
    endfunction

    function automatic void put_byte(input logic [7:0] b);
        stream_bytes.push_back({1'b0, b});
    endfunction

    function automatic void put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++) put_byte(v[8*i +: 8]);
    endfunction

    function automatic void put_tag(input logic [31:0] v);
        for (int i = 3; i >= 0; i--) put_byte(v[8*i +: 8]);
    endfunction

    function automatic logic [7:0] sample_byte();
        logic [7:0] edges[4] = '{8'h00, 8'hFF, 8'h7F, 8'h80};
        if ($urandom_range(0, 7) == 0) return edges[$urandom_range(0, 3)];
        return 8'($urandom_range(0, 255));
    endfunction

    // A 16-bit fmt field that is neither good value; some keep a good low byte.
    function automatic logic [15:0] bad_word(input logic [15:0] ok_a, input logic [15:0] ok_b);
        logic [15:0] w;
        case ($urandom_range(0, 3))
            0: w = 16'h0000;
            1: w = 16'hFFFF;
            2: w = {8'($urandom_range(1, 255)), ok_a[7:0]};
            default: w = 16'($urandom_range(0, 65535));
        endcase
        if (w == ok_a || w == ok_b) w = 16'h0000;
        return w;
    endfunction

    // Build one byte stream: mostly well-formed files with random content,
    // the rest broken headers, truncated files and raw noise. Every stream
    // ends with an end-of-stream transaction.
    task automatic build_stream(input bit long_run);
        int          sel, idx, n, nfmt, fmt_len, data_len;
        bit          huge;
        logic [15:0] fmt_code, ch, bits;
        logic [31:0] rate;
        stream_bytes.delete();
        sel = long_run ? 99 : $urandom_range(0, 99);
        if (sel < 6) begin
            n = $urandom_range(1, 8);
            repeat (n) stream_bytes.push_back({($urandom_range(0, 3) == 0), sample_byte()});
            stream_bytes.push_back({1'b1, 8'($urandom_range(0, 255))});
            return;
        end
        put_tag(TAG_RIFF);
        put_le($urandom, 4);
        put_tag(TAG_WAVE);
        if (sel < 14) begin
            // Corrupt one byte of either tag.
            idx = $urandom_range(0, 7);
            if (idx >= 4) idx = idx + 4;
            stream_bytes[idx].b = stream_bytes[idx].b ^ 8'($urandom_range(1, 255));
        end
        if (!long_run && $urandom_range(0, 3) == 0) begin
            put_tag($urandom);
            huge = ($urandom_range(0, 15) == 0);
            n    = huge ? 0 : $urandom_range(0, 6);
            put_le(huge ? $urandom : 32'(n), 4);
            repeat (n) put_byte(sample_byte());
        end
        // Fmt chunk count: none for data before fmt, two now and then, else one.
        nfmt = (sel >= 32 && sel < 38) ? 0 : ((sel >= 38 && $urandom_range(0, 5) == 0) ? 2 : 1);
        for (int k = 0; k < nfmt; k++) begin
            fmt_code = 16'd1;
            ch       = long_run ? 16'd1 : 16'($urandom_range(1, 2));
            bits     = (long_run || $urandom_range(0, 1) == 0) ? 16'd8 : 16'd16;
            if (k == nfmt - 1) begin
                if (sel >= 14 && sel < 20) fmt_code = bad_word(16'd1, 16'd1);
                else if (sel >= 20 && sel < 26) ch = bad_word(16'd1, 16'd2);
                else if (sel >= 26 && sel < 32) bits = bad_word(16'd8, 16'd16);
            end
            case ($urandom_range(0, 3))
                1: fmt_len = $urandom_range(0, 15);
                2: fmt_len = 16 + $urandom_range(1, 5);
                default: fmt_len = 16;
            endcase
            case ($urandom_range(0, 5))
                0: rate = 32'h0000_0000;
                1: rate = 32'hFFFF_FFFF;
                default: rate = $urandom;
            endcase
            put_tag(TAG_FMT);
            put_le(32'(fmt_len), 4);
            put_le(32'(fmt_code), 2);
            put_le(32'(ch), 2);
            put_le(rate, 4);
            put_le($urandom, 4);
            put_le($urandom, 2);
            put_le(32'(bits), 2);
            repeat ((fmt_len > 16) ? fmt_len - 16 : 0) put_byte(sample_byte());
        end
        put_tag(TAG_DATA);
        huge     = !long_run && ($urandom_range(0, 19) == 0);
        data_len = long_run ? 60 : $urandom_range(0, 24);
        put_le(huge ? $urandom : 32'(data_len), 4);
        repeat (data_len) put_byte(sample_byte());
        // Trailing bytes follow the data; unless the length field is huge, they are ignored.
        repeat ($urandom_range(0, 3)) put_byte(sample_byte());
        if (!long_run && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, stream_bytes.size() - 1);
            while (stream_bytes.size() > n) void'(stream_bytes.pop_back());
        end
        stream_bytes.push_back({1'b1, 8'($urandom_range(0, 255))});
    endtask

    // Offer one transaction after a random idle stretch; predict once it is taken.
    task automatic send_byte(input logic op, input logic [7:0] b, input bit fixed,
                             input wav_res_t fixed_res);
        int       gap;
        bit       hit;
        wav_res_t res;
        gap = pick_gap(tx_burst);
        if (gap > 0) begin
            i_push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_push      <= 1'b1;
        i_op        <= op;
        i_data_byte <= b;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        // Bytes after a finished or rejected header are dropped by the block.
        if (op || ph != PH_DONE) useful_items = useful_items + 1;
        hit = decode_step(op, b, res);
        if (fixed) pending_results.push_back(fixed_res);
        else if (hit) pending_results.push_back(res);
    endtask

    // Count cycles in which the sender is held back by a full queue.
    always @(posedge i_clk) begin
        if (i_rst_n && i_push && o_full) full_cycles <= full_cycles + 1;
    end

    // Long receiver hold-off, counted here, started by the stimulus process.
    initial begin : hold_off
        wait (hold_req);
        @(posedge i_clk);
        hold_rx <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rx <= 1'b0;
    end

    // Result side: pop with random gaps and compare each transaction to the oldest prediction.
    initial begin : result_sink
        int       gap;
        bit       bad;
        wav_res_t got;
        wav_res_t want;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            gap = pick_gap(rx_burst);
            if (gap > 0) begin
                i_pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            while (hold_rx) begin
                i_pop <= 1'b0;
                @(posedge i_clk);
            end
            i_pop <= 1'b1;
            @(posedge i_clk);
            while (o_empty) @(posedge i_clk);
            // Outputs read here still hold the values taken at this edge.
            got = {t_kind'(o_kind), o_sample, o_channels, o_sample_rate, o_bits_per_sample,
                   o_total_samples, o_reject_cause, o_last};
            kind_seen[o_kind] = kind_seen[o_kind] + 1;
            if (pending_results.size() == 0) begin
                note_error($sformatf("unexpected result at %0t: kind=%0d sample=%0d",
                                     $time, got.kind, $signed(got.sample)));
            end else begin
                want = pending_results.pop_front();
                bad  = (got.kind !== want.kind) || (got.sample !== want.sample)
                    || (got.channels !== want.channels) || (got.rate !== want.rate)
                    || (got.bits !== want.bits) || (got.total !== want.total)
                    || (got.cause !== want.cause) || (got.last !== want.last);
                if (bad) begin
                    note_error($sformatf({"mismatch at %0t\n",
                        "  want kind=%0d sample=%0d ch=%0d rate=%h bits=%0d total=%0d cause=%0d last=%0d\n",
                        "  got  kind=%0d sample=%0d ch=%0d rate=%h bits=%0d total=%0d cause=%0d last=%0d"},
                        $time,
                        want.kind, $signed(want.sample), want.channels, want.rate, want.bits,
                        want.total, want.cause, want.last,
                        got.kind, $signed(got.sample), got.channels, got.rate, got.bits,
                        got.total, got.cause, got.last));
                end
            end
        end
    end

    // Stimulus: reset, directed table, then random streams; finally drain and report.
    initial begin : stimulus
        int waited;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        parser_restart();

        // End of stream straight after reset reports an early end.
        add_row_exp(1'b1, 8'h00, KIND_EARLY_END, '0);
        // Bad RIFF tag rejects on its fourth byte; later bytes are dropped.
        add_row(1'b0, "R");
        add_row(1'b0, "I");
        add_row(1'b0, "F");
        add_row_exp(1'b0, 8'hFF, KIND_REJECT, CAUSE_BAD_TAG);
        add_row(1'b0, 8'h00);
        // End of stream after a reject says nothing.
        add_row(1'b1, 8'hFF);
        // Good RIFF, extreme size bytes, bad WAVE tag rejects on byte twelve.
        add_row(1'b0, "R");
        add_row(1'b0, "I");
        add_row(1'b0, "F");
        add_row(1'b0, "F");
        add_row(1'b0, 8'h00);
        add_row(1'b0, 8'hFF);
        add_row(1'b0, 8'h00);
        add_row(1'b0, 8'hFF);
        add_row(1'b0, "W");
        add_row(1'b0, "A");
        add_row(1'b0, "V");
        add_row_exp(1'b0, 8'h00, KIND_REJECT, CAUSE_BAD_TAG);
        add_row(1'b1, 8'h00);
        // Stream cut inside the RIFF tag.
        add_row(1'b0, "R");
        add_row(1'b0, "I");
        add_row(1'b0, "F");
        add_row_exp(1'b1, 8'hFF, KIND_EARLY_END, '0);

        foreach (dir_rows[i]) send_byte(dir_rows[i].s.op, dir_rows[i].s.b,
                                        dir_rows[i].fixed, dir_rows[i].want);
        useful_items = 0;

        while (useful_items < ITEMS) begin
            // The third stream is a long 8-bit file sent back to back while the
            // receiver holds off, so the result queue fills and stalls the input.
            if (stream_cnt == 2) begin
                hold_req = 1'b1;
                tx_burst = 200;
            end
            build_stream(stream_cnt == 2);
            foreach (stream_bytes[i]) send_byte(stream_bytes[i].op, stream_bytes[i].b, 1'b0, '0);
            stream_cnt = stream_cnt + 1;
        end
        i_push <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited = waited + 1;
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            note_error($sformatf("%0d expected results never arrived", pending_results.size()));
        end

        $display("covered %0d random streams, %0d useful bytes;", stream_cnt, useful_items);
        $display("saw %0d samples, %0d headers, %0d rejects, %0d early ends",
                 kind_seen[KIND_SAMPLE], kind_seen[KIND_HEADER],
                 kind_seen[KIND_REJECT], kind_seen[KIND_EARLY_END]);
        $display("input held off by a full queue for %0d cycles; %0d errors", full_cycles, err_cnt);
        if (err_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // Hard stop well past the slowest legal run.
    initial begin : watchdog
        #2_000_000;
        $display("timeout: decoder stopped making progress");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
